// ----- src/his_pkg.sv -----
// Shared widths, command and status types for the homography inlier scoring unit.
package his_pkg;

   localparam int CoefW     = 48;
   localparam int PtW       = 24;
   localparam int ThrW      = 24;
   localparam int ErrW      = 48;
   localparam int CntW      = 16;
   localparam int AccW      = 58;
   localparam int QuotW     = 48;
   localparam int MulW      = 25;
   localparam int ProdW     = 2 * MulW;
   localparam int NumCoef   = 9;
   localparam int ProjSteps = 12;
   localparam int DivSteps  = 48;
   localparam int SqSteps   = 3;
   localparam int MaxBatch  = 65535;

   localparam logic [CntW-1:0] CntLimit = CntW'((MaxBatch < 65535) ? MaxBatch : 65535);
   localparam logic [ErrW-1:0] ErrMax   = {ErrW{1'b1}};
   localparam logic [ThrW-1:0] ThrReset = ThrW'(768);

   typedef enum logic [1:0] {
      MS_PROJ,
      MS_SQX,
      MS_SQY,
      MS_TH
   } mul_sel_type;

   typedef struct packed {
      logic        accept;
      logic        acc_init;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic [3:0]  step;
      logic        div_start;
      logic        div_step;
      logic        diff_en;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } sts_type;

endpackage

// ----- src/his_ctrl.sv -----
// Sequencer that steps the datapath through projection, division and squaring.
module his_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_func,
   input  his_pkg::sts_type sts,
   output logic             req_stall,
   output his_pkg::cmd_type cmd
);
   import his_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PROJ,
      S_PDRAIN,
      S_DSTART,
      S_DIV,
      S_DIFF,
      S_SQ,
      S_SDRAIN,
      S_OUT
   } state_type;

   state_type  state_ff;
   logic [5:0] cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               cnt_ff <= '0;
               if (req_valid && req_func) state_ff <= S_PROJ;
            end
            S_PROJ: begin
               if (cnt_ff == 6'(ProjSteps - 1)) begin
                  state_ff <= S_PDRAIN;
                  cnt_ff   <= '0;
               end else begin
                  cnt_ff <= cnt_ff + 6'd1;
               end
            end
            S_PDRAIN: state_ff <= S_DSTART;
            S_DSTART: begin
               state_ff <= S_DIV;
               cnt_ff   <= '0;
            end
            S_DIV: begin
               if (cnt_ff == 6'(DivSteps - 1)) begin
                  state_ff <= S_DIFF;
                  cnt_ff   <= '0;
               end else begin
                  cnt_ff <= cnt_ff + 6'd1;
               end
            end
            S_DIFF: begin
               state_ff <= S_SQ;
               cnt_ff   <= '0;
            end
            S_SQ: begin
               if (cnt_ff == 6'(SqSteps - 1)) begin
                  state_ff <= S_SDRAIN;
                  cnt_ff   <= '0;
               end else begin
                  cnt_ff <= cnt_ff + 6'd1;
               end
            end
            S_SDRAIN: state_ff <= S_OUT;
            S_OUT: begin
               if (sts.out_free) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_comb begin
      cmd         = '0;
      cmd.mul_sel = MS_PROJ;
      case (state_ff)
         S_IDLE: begin
            cmd.accept   = req_valid;
            cmd.acc_init = req_valid && req_func;
         end
         S_PROJ: begin
            cmd.mul_en = 1'b1;
            cmd.step   = cnt_ff[3:0];
         end
         S_DSTART: cmd.div_start = 1'b1;
         S_DIV:    cmd.div_step  = 1'b1;
         S_DIFF:   cmd.diff_en   = 1'b1;
         S_SQ: begin
            cmd.mul_en = 1'b1;
            if (cnt_ff == 6'd0) begin
               cmd.mul_sel = MS_SQX;
            end else if (cnt_ff == 6'd1) begin
               cmd.mul_sel = MS_SQY;
            end else begin
               cmd.mul_sel = MS_TH;
            end
         end
         S_OUT:    cmd.out_load = sts.out_free;
         default:  cmd.accept   = 1'b0;
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

// ----- src/his_dp.sv -----
// Datapath: coefficient store, shared multiplier, accumulators, divider and result register.
module his_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  his_pkg::cmd_type                    cmd,
   input  logic                                req_func,
   input  logic [3:0]                          req_coef_index,
   input  logic signed [his_pkg::CoefW-1:0]    req_coef_value,
   input  logic signed [his_pkg::PtW-1:0]      req_src_x,
   input  logic signed [his_pkg::PtW-1:0]      req_src_y,
   input  logic signed [his_pkg::PtW-1:0]      req_dst_x,
   input  logic signed [his_pkg::PtW-1:0]      req_dst_y,
   input  logic                                req_last_point,
   input  logic [his_pkg::ThrW-1:0]            thr,
   input  logic                                rsp_stall,
   output his_pkg::sts_type                    sts,
   output logic                                rsp_valid,
   output logic [his_pkg::ErrW-1:0]            rsp_sq_error,
   output logic                                rsp_is_inlier,
   output logic                                rsp_degenerate,
   output logic [his_pkg::CntW-1:0]            rsp_inlier_count,
   output logic                                rsp_batch_end
);
   import his_pkg::*;

   logic signed [CoefW-1:0] coef_ff [NumCoef];
   logic signed [PtW-1:0]   sx_ff, sy_ff, dstx_ff, dsty_ff;
   logic                    last_ff;

   logic signed [MulW-1:0]  op_a, op_b;
   logic signed [ProdW-1:0] prod_ff;
   logic                    pvld_ff;
   mul_sel_type             psel_ff;
   logic [3:0]              pstep_ff;

   logic signed [AccW-1:0]  acc_ff [3];
   logic [AccW-1:0]         den_ff, remx_ff, remy_ff;
   logic [QuotW-1:0]        qx_ff, qy_ff;
   logic                    ovx_ff, ovy_ff, negx_ff, negy_ff, degen_ff;
   logic [PtW-1:0]          magx_ff, magy_ff;
   logic                    sat_ff;
   logic [ErrW-1:0]         sqx_ff, sqy_ff, thsq_ff;
   logic [CntW-1:0]         running_ff;

   logic                    rsp_valid_ff;
   logic [ErrW-1:0]         rsp_err_ff;
   logic                    rsp_inl_ff, rsp_degen_ff, rsp_end_ff;
   logic [CntW-1:0]         rsp_cnt_ff;

   // Operand selection for the shared multiplier.
   logic [2:0]              term;
   logic [3:0]              cidx;
   logic signed [CoefW-1:0] csel;
   logic signed [PtW-1:0]   coord;

   always_comb begin
      term = cmd.step[3:1];
      case (term)
         3'd0:    cidx = 4'd0;
         3'd1:    cidx = 4'd1;
         3'd2:    cidx = 4'd3;
         3'd3:    cidx = 4'd4;
         3'd4:    cidx = 4'd6;
         3'd5:    cidx = 4'd7;
         default: cidx = 4'd0;
      endcase
      csel  = coef_ff[cidx];
      coord = term[0] ? sy_ff : sx_ff;
      case (cmd.mul_sel)
         MS_PROJ: begin
            // The coefficient is split into a signed high half and an unsigned low half.
            op_a = cmd.step[0] ? $signed({1'b0, csel[23:0]}) : $signed({csel[47], csel[47:24]});
            op_b = $signed({coord[PtW-1], coord});
         end
         MS_SQX: begin
            op_a = $signed({1'b0, magx_ff});
            op_b = $signed({1'b0, magx_ff});
         end
         MS_SQY: begin
            op_a = $signed({1'b0, magy_ff});
            op_b = $signed({1'b0, magy_ff});
         end
         MS_TH: begin
            op_a = $signed({1'b0, thr});
            op_b = $signed({1'b0, thr});
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff  <= op_a * op_b;
      psel_ff  <= cmd.mul_sel;
      pstep_ff <= cmd.step;
      if (reset) begin
         pvld_ff <= 1'b0;
      end else begin
         pvld_ff <= cmd.mul_en;
      end
   end

   // Coefficient store and point capture.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumCoef; i++) coef_ff[i] <= '0;
      end else if (cmd.accept && !req_func && (req_coef_index < 4'(NumCoef))) begin
         coef_ff[req_coef_index] <= req_coef_value;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.acc_init) begin
         sx_ff   <= req_src_x;
         sy_ff   <= req_src_y;
         dstx_ff <= req_dst_x;
         dsty_ff <= req_dst_y;
         last_ff <= req_last_point;
      end
   end

   // Projection accumulators; each product is floored to scale 2^16 on its own.
   logic signed [AccW-1:0] term_add;
   logic [1:0]             tgt;

   always_comb begin
      tgt = pstep_ff[3:2];
      if (pstep_ff[0]) begin
         term_add = AccW'(prod_ff >>> 16);
      end else begin
         term_add = $signed({prod_ff, 8'b0});
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.acc_init) begin
         acc_ff[0] <= AccW'(coef_ff[2] >>> 8);
         acc_ff[1] <= AccW'(coef_ff[5] >>> 8);
         acc_ff[2] <= AccW'(coef_ff[8] >>> 8);
      end else if (pvld_ff && (psel_ff == MS_PROJ) && (tgt != 2'd3)) begin
         acc_ff[tgt] <= acc_ff[tgt] + term_add;
      end
   end

   // Restoring divider, one quotient bit per cycle for both coordinates.
   logic [AccW-1:0] numx, numy, denm;
   logic [AccW:0]   trialx, trialy;

   always_comb begin
      numx   = acc_ff[0][AccW-1] ? AccW'(-acc_ff[0]) : acc_ff[0];
      numy   = acc_ff[1][AccW-1] ? AccW'(-acc_ff[1]) : acc_ff[1];
      denm   = acc_ff[2][AccW-1] ? AccW'(-acc_ff[2]) : acc_ff[2];
      trialx = {remx_ff, qx_ff[QuotW-1]};
      trialy = {remy_ff, qy_ff[QuotW-1]};
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         den_ff   <= denm;
         remx_ff  <= AccW'(numx[AccW-1:40]);
         remy_ff  <= AccW'(numy[AccW-1:40]);
         qx_ff    <= {numx[39:0], 8'b0};
         qy_ff    <= {numy[39:0], 8'b0};
         ovx_ff   <= AccW'(numx[AccW-1:40]) >= denm;
         ovy_ff   <= AccW'(numy[AccW-1:40]) >= denm;
         negx_ff  <= acc_ff[0][AccW-1] ^ acc_ff[2][AccW-1];
         negy_ff  <= acc_ff[1][AccW-1] ^ acc_ff[2][AccW-1];
         degen_ff <= (acc_ff[2] == '0);
      end else if (cmd.div_step) begin
         if (trialx >= {1'b0, den_ff}) begin
            remx_ff <= AccW'(trialx - {1'b0, den_ff});
            qx_ff   <= {qx_ff[QuotW-2:0], 1'b1};
         end else begin
            remx_ff <= trialx[AccW-1:0];
            qx_ff   <= {qx_ff[QuotW-2:0], 1'b0};
         end
         if (trialy >= {1'b0, den_ff}) begin
            remy_ff <= AccW'(trialy - {1'b0, den_ff});
            qy_ff   <= {qy_ff[QuotW-2:0], 1'b1};
         end else begin
            remy_ff <= trialy[AccW-1:0];
            qy_ff   <= {qy_ff[QuotW-2:0], 1'b0};
         end
      end
   end

   // Signed differences against the destination point.
   logic signed [QuotW+1:0] sqx_s, sqy_s, difx, dify;
   logic [QuotW+1:0]        mgx, mgy;

   always_comb begin
      sqx_s = negx_ff ? -$signed({2'b0, qx_ff}) : $signed({2'b0, qx_ff});
      sqy_s = negy_ff ? -$signed({2'b0, qy_ff}) : $signed({2'b0, qy_ff});
      difx  = (QuotW+2)'(dstx_ff) - sqx_s;
      dify  = (QuotW+2)'(dsty_ff) - sqy_s;
      mgx   = difx[QuotW+1] ? (QuotW+2)'(-difx) : difx;
      mgy   = dify[QuotW+1] ? (QuotW+2)'(-dify) : dify;
   end

   always_ff @(posedge clock) begin
      if (cmd.diff_en) begin
         magx_ff <= mgx[PtW-1:0];
         magy_ff <= mgy[PtW-1:0];
         sat_ff  <= ovx_ff || ovy_ff || (mgx[QuotW+1:PtW] != '0) || (mgy[QuotW+1:PtW] != '0);
      end
      if (pvld_ff) begin
         case (psel_ff)
            MS_SQX:  sqx_ff  <= prod_ff[ErrW-1:0];
            MS_SQY:  sqy_ff  <= prod_ff[ErrW-1:0];
            MS_TH:   thsq_ff <= prod_ff[ErrW-1:0];
            default: thsq_ff <= thsq_ff;
         endcase
      end
   end

   // Final sum, threshold compare and batch count.
   logic [ErrW:0]   sum;
   logic [ErrW-1:0] err;
   logic            inl;
   logic [CntW-1:0] cnt_next;

   always_comb begin
      sum      = {1'b0, sqx_ff} + {1'b0, sqy_ff};
      err      = (degen_ff || sat_ff || sum[ErrW]) ? ErrMax : sum[ErrW-1:0];
      inl      = !degen_ff && (err <= thsq_ff);
      cnt_next = (inl && (running_ff < CntLimit)) ? running_ff + 1'b1 : running_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         running_ff   <= '0;
      end else begin
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
            running_ff   <= last_ff ? '0 : cnt_next;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_err_ff   <= err;
         rsp_inl_ff   <= inl;
         rsp_degen_ff <= degen_ff;
         rsp_cnt_ff   <= cnt_next;
         rsp_end_ff   <= last_ff;
      end
   end

   assign sts.out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sq_error     = rsp_err_ff;
   assign rsp_is_inlier    = rsp_inl_ff;
   assign rsp_degenerate   = rsp_degen_ff;
   assign rsp_inlier_count = rsp_cnt_ff;
   assign rsp_batch_end    = rsp_end_ff;

endmodule

// ----- src/homography_inlier_scoring_unit.sv -----
// Homography inlier scoring unit: CSR, controller and datapath.
// The req channel carries one item per handshake (valid high, stall low).
// A load item (func 0) writes one Q24.24 coefficient at row*3+col and
// leaves the unit idle; it gives no result. A point item (func 1) projects
// the source point through the stored homography, divides by the third
// component and reports the squared transfer error, the inlier flag, the
// degenerate flag and the running inlier count of the batch.
// A point occupies the unit through projection on the shared 25x25
// multiplier, the bit-serial divider (one quotient bit per cycle for x
// and y together), the squares and the threshold on the multiplier, and
// the sequencing states between them. When the sequence ends, the result
// is loaded into the output register that drives rsp.
// The result sits in an output register; while rsp is stalled the next
// item is still accepted and computed, and it waits in its final step
// until the held result is taken.
// Synchronous reset clears the coefficients, the inlier count and the
// threshold (to 3.0 pixels). The threshold lives at CSR address 0.
module homography_inlier_scoring_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_func,
   input  logic [3:0]                        req_coef_index,
   input  logic signed [his_pkg::CoefW-1:0]  req_coef_value,
   input  logic signed [his_pkg::PtW-1:0]    req_src_x,
   input  logic signed [his_pkg::PtW-1:0]    req_src_y,
   input  logic signed [his_pkg::PtW-1:0]    req_dst_x,
   input  logic signed [his_pkg::PtW-1:0]    req_dst_y,
   input  logic                              req_last_point,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [his_pkg::ErrW-1:0]          rsp_sq_error,
   output logic                              rsp_is_inlier,
   output logic                              rsp_degenerate,
   output logic [his_pkg::CntW-1:0]          rsp_inlier_count,
   output logic                              rsp_batch_end,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [2:0]                        csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);
   import his_pkg::*;

   logic [ThrW-1:0] thr_ff;
   cmd_type         cmd;
   sts_type         sts;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= ThrReset;
      end else if (csr_psel && csr_penable && csr_pwrite && !csr_paddr[2]) begin
         thr_ff <= csr_pwdata[ThrW-1:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[2] ? 32'd0 : {8'd0, thr_ff};

   his_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .sts       (sts),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   his_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_func         (req_func),
      .req_coef_index   (req_coef_index),
      .req_coef_value   (req_coef_value),
      .req_src_x        (req_src_x),
      .req_src_y        (req_src_y),
      .req_dst_x        (req_dst_x),
      .req_dst_y        (req_dst_y),
      .req_last_point   (req_last_point),
      .thr              (thr_ff),
      .rsp_stall        (rsp_stall),
      .sts              (sts),
      .rsp_valid        (rsp_valid),
      .rsp_sq_error     (rsp_sq_error),
      .rsp_is_inlier    (rsp_is_inlier),
      .rsp_degenerate   (rsp_degenerate),
      .rsp_inlier_count (rsp_inlier_count),
      .rsp_batch_end    (rsp_batch_end)
   );

   a_degen_outlier: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> !rsp_is_inlier && (rsp_sq_error == ErrMax))
      else $error("degenerate point reported as inlier or unsaturated");

   a_inlier_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_inlier |-> (rsp_inlier_count != '0))
      else $error("inlier reported with zero count");

   a_point_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_func |=> req_stall)
      else $error("unit not busy after taking a point");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_func |=> !req_stall)
      else $error("unit busy after a coefficient load");

endmodule

// ----- verif/his_checker.sv -----
// Checker for the homography inlier scoring unit: predicts each scored item and compares.
`timescale 1ns / 100ps
module his_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic                              req_func,
   input  logic [3:0]                        req_coef_index,
   input  logic signed [his_pkg::CoefW-1:0]  req_coef_value,
   input  logic signed [his_pkg::PtW-1:0]    req_src_x,
   input  logic signed [his_pkg::PtW-1:0]    req_src_y,
   input  logic signed [his_pkg::PtW-1:0]    req_dst_x,
   input  logic signed [his_pkg::PtW-1:0]    req_dst_y,
   input  logic                              req_last_point,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [his_pkg::ErrW-1:0]          rsp_sq_error,
   input  logic                              rsp_is_inlier,
   input  logic                              rsp_degenerate,
   input  logic [his_pkg::CntW-1:0]          rsp_inlier_count,
   input  logic                              rsp_batch_end,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [2:0]                        csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   input  logic                              csr_pready,
   output int                                fail_count,
   output int                                pending
);
   import his_pkg::*;

   localparam logic [2:0] AddrThreshold = 3'd0;
   localparam logic       FuncLoad      = 1'b0;

   typedef struct packed {
      logic [ErrW-1:0] sq_error;
      logic            is_inlier;
      logic            degenerate;
      logic [CntW-1:0] inlier_count;
      logic            batch_end;
   } score_type;

   score_type             score_q[$];
   logic signed [CoefW-1:0] homography[NumCoef];
   logic [CntW-1:0]       batch_inliers;
   logic [ThrW-1:0]       threshold;

   // Product of a Q24.24 coefficient and a Q16.8 coordinate, floored to scale 2^16.
   function automatic longint coef_times_coord(longint c, longint s);
      longint hi, lo;
      hi = c >>> 24;
      lo = c - hi * 64'sd16777216;
      return hi * s * 256 + ((lo * s) >>> 16);
   endfunction

   // Quotient in Q.8 truncated toward zero; returns 0 when the integer part overflows.
   function automatic bit divide_q8(longint num, longint den, output longint q);
      longint unsigned un, ud, qi, r, fr;
      un = (num < 0) ? longint'(-num) : num;
      ud = (den < 0) ? longint'(-den) : den;
      qi = un / ud;
      r  = un % ud;
      fr = 0;
      q  = 0;
      if (qi >= (64'd1 << 40)) return 1'b0;
      for (int i = 0; i < 8; i++) begin
         r  = r << 1;
         fr = fr << 1;
         if (r >= ud) begin
            r  = r - ud;
            fr = fr | 1;
         end
      end
      q = longint'((qi << 8) | fr);
      if ((num < 0) != (den < 0)) q = -q;
      return 1'b1;
   endfunction

   function automatic bit square_q16(longint d, output longint unsigned sq);
      longint unsigned m;
      m  = (d < 0) ? longint'(-d) : d;
      sq = m * m;
      return m < (64'd1 << 24);
   endfunction

   function automatic score_type score_point();
      score_type           s;
      longint              sx, sy, px, py, pw, qx, qy;
      longint unsigned     sqx, sqy, err, th;
      sx = req_src_x;
      sy = req_src_y;
      px = coef_times_coord(homography[0], sx) + coef_times_coord(homography[1], sy)
           + (longint'(homography[2]) >>> 8);
      py = coef_times_coord(homography[3], sx) + coef_times_coord(homography[4], sy)
           + (longint'(homography[5]) >>> 8);
      pw = coef_times_coord(homography[6], sx) + coef_times_coord(homography[7], sy)
           + (longint'(homography[8]) >>> 8);
      err = ErrMax;
      s.degenerate = (pw == 0);
      if (!s.degenerate && divide_q8(px, pw, qx) && divide_q8(py, pw, qy) &&
          square_q16(longint'(req_dst_x) - qx, sqx) &&
          square_q16(longint'(req_dst_y) - qy, sqy)) begin
         err = sqx + sqy;
         if (err > ErrMax) err = ErrMax;
      end
      th = threshold;
      s.is_inlier = !s.degenerate && (err <= th * th);
      if (s.is_inlier && batch_inliers < CntLimit) batch_inliers = batch_inliers + 1'b1;
      s.sq_error     = err[ErrW-1:0];
      s.inlier_count = batch_inliers;
      s.batch_end    = req_last_point;
      if (req_last_point) batch_inliers = '0;
      return s;
   endfunction

   always @(posedge clock) begin
      score_type want;
      int        errs;
      errs = 0;
      if (reset) begin
         score_q.delete();
         foreach (homography[i]) homography[i] = '0;
         batch_inliers = '0;
         threshold     = ThrReset;
         fail_count   <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == AddrThreshold)
            threshold = csr_pwdata[ThrW-1:0];
         if (rsp_valid && !rsp_stall) begin
            if (score_q.size() == 0) begin
               $error("result arrived with no item outstanding");
               errs++;
            end else begin
               want = score_q.pop_front();
               if (rsp_sq_error !== want.sq_error) begin
                  $error("sq_error: expected %0h, got %0h", want.sq_error, rsp_sq_error);
                  errs++;
               end
               if (rsp_is_inlier !== want.is_inlier) begin
                  $error("is_inlier: expected %0b, got %0b", want.is_inlier, rsp_is_inlier);
                  errs++;
               end
               if (rsp_degenerate !== want.degenerate) begin
                  $error("degenerate: expected %0b, got %0b", want.degenerate, rsp_degenerate);
                  errs++;
               end
               if (rsp_inlier_count !== want.inlier_count) begin
                  $error("inlier_count: expected %0d, got %0d",
                         want.inlier_count, rsp_inlier_count);
                  errs++;
               end
               if (rsp_batch_end !== want.batch_end) begin
                  $error("batch_end: expected %0b, got %0b", want.batch_end, rsp_batch_end);
                  errs++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (req_func == FuncLoad) begin
               if (req_coef_index < NumCoef) homography[req_coef_index] = req_coef_value;
            end else begin
               score_q.push_back(score_point());
            end
         end
         fail_count <= fail_count + errs;
      end
      pending <= score_q.size();
   end

endmodule

// ----- verif/tb.sv -----
// Testbench top for the homography inlier scoring unit: stimulus, pacing and verdict.
`timescale 1ns / 100ps
module tb;
   import his_pkg::*;

   localparam logic       FuncLoad      = 1'b0;
   localparam logic       FuncScore     = 1'b1;
   localparam logic [2:0] AddrThreshold = 3'd0;
   localparam longint     One           = 64'sd1 << 24;
   localparam int         WatchLimit    = 5000;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_stall, req_func = 0, req_last_point = 0;
   logic [3:0] req_coef_index = '0;
   logic signed [CoefW-1:0] req_coef_value = '0;
   logic signed [PtW-1:0] req_src_x = '0, req_src_y = '0, req_dst_x = '0, req_dst_y = '0;
   logic rsp_valid, rsp_stall = 0, rsp_is_inlier, rsp_degenerate, rsp_batch_end;
   logic [ErrW-1:0] rsp_sq_error;
   logic [CntW-1:0] rsp_inlier_count;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0, csr_pready;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0, csr_prdata;
   int fail_count, pending;
   int n_loads = 0, n_points = 0, n_results = 0, watch = 0;
   bit quiet = 0, hold_req = 0;

   homography_inlier_scoring_unit dut (.*);
   his_checker u_checker (.*);

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) n_results <= n_results + 1;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel)
         watch <= 0;
      else
         watch <= watch + 1;
      if (watch >= WatchLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Result side: short random stalls, plus one long hold so the unit backs up.
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 0;
            rsp_stall <= 1;
            repeat (300) @(posedge clock);
            rsp_stall <= 0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1;
            repeat ($urandom_range(1, 3)) @(posedge clock);
            rsp_stall <= 0;
         end
      end
   end

   task automatic offer(logic func, logic [3:0] idx, logic [CoefW-1:0] coef,
                        logic [PtW-1:0] sx, logic [PtW-1:0] sy,
                        logic [PtW-1:0] dx, logic [PtW-1:0] dy, logic last);
      req_valid      <= 1;
      req_func       <= func;
      req_coef_index <= idx;
      req_coef_value <= coef;
      req_src_x      <= sx;
      req_src_y      <= sy;
      req_dst_x      <= dx;
      req_dst_y      <= dy;
      req_last_point <= last;
      do @(posedge clock); while (req_stall);
      if (func == FuncLoad) n_loads++; else n_points++;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic load_coef(int idx, longint value);
      offer(FuncLoad, idx[3:0], value[CoefW-1:0], PtW'($urandom), PtW'($urandom),
            PtW'($urandom), PtW'($urandom), 1'($urandom_range(0, 1)));
   endtask

   task automatic score(longint sx, longint sy, longint dx, longint dy, bit last);
      offer(FuncScore, 4'($urandom), CoefW'({$urandom, $urandom}), sx[PtW-1:0], sy[PtW-1:0],
            dx[PtW-1:0], dy[PtW-1:0], last);
   endtask

   task automatic load_affine(longint tx, longint ty, longint skew);
      longint h[9];
      h = '{One, skew, tx << 24, -skew, One, ty << 24, 0, 0, One};
      for (int i = 0; i < 9; i++) load_coef(i, h[i]);
   endtask

   // Lets every outstanding item drain before the threshold changes.
   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      wait (pending == 0);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_threshold(logic [31:0] value);
      csr_psel    <= 1;
      csr_pwrite  <= 1;
      csr_paddr   <= AddrThreshold;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel    <= 0;
      csr_penable <= 0;
      csr_pwrite  <= 0;
      @(posedge clock);
   endtask

   task automatic random_phase(int count);
      longint tx, ty, skew, sx, sy, ex, ey;
      int stop, size;
      stop = n_loads + n_points + count;
      while (n_loads + n_points < stop) begin
         if ($urandom_range(0, 99) < 80) begin
            tx   = $signed($urandom_range(0, 200)) - 100;
            ty   = $signed($urandom_range(0, 200)) - 100;
            skew = ($urandom_range(0, 3) == 0) ? $signed($urandom_range(0, 4000)) - 2000 : 0;
            load_affine(tx, ty, skew);
            if ($urandom_range(0, 4) == 0)
               load_coef($urandom_range(0, 8), longint'({$urandom, $urandom} >> 16));
            size = $urandom_range(1, 10);
            for (int p = 0; p < size; p++) begin
               sx = $signed($urandom_range(0, 400000)) - 200000;
               sy = $signed($urandom_range(0, 400000)) - 200000;
               ex = $signed($urandom_range(0, 1600)) - 800;
               ey = $signed($urandom_range(0, 1600)) - 800;
               score(sx, sy, sx + tx * 256 + ex, sy + ty * 256 + ey, p == size - 1);
            end
         end else if ($urandom_range(0, 1) == 0) begin
            load_coef($urandom_range(0, 15), longint'({$urandom, $urandom}));
         end else begin
            score(longint'($urandom), longint'($urandom), longint'($urandom),
                  longint'($urandom), 1'($urandom_range(0, 1)));
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: zero model, ignored loads, identity, coordinate extremes, overflow.
      score(0, 0, 0, 0, 1);
      load_coef(15, 64'sh7FFF_FFFF_FFFF);
      load_coef(9, One);
      load_affine(0, 0, 0);
      score(0, 0, 0, 0, 0);
      score(8388607, 8388607, 8388607, 8388607, 0);
      score(-8388608, -8388608, -8388608, -8388608, 0);
      score(8388607, 8388607, -8388608, -8388608, 1);
      score(100, -100, 400, -400, 1);
      load_coef(8, 1);
      score(0, 0, 0, 0, 0);
      load_coef(8, 256);
      load_coef(0, 64'sh7FFF_FFFF_FFFF);
      score(8388607, 0, 0, 0, 0);
      load_coef(8, -(64'sd1 << 47));
      score(-8388608, 8388607, 5, 5, 1);
      drain();

      write_threshold(0);
      random_phase(90);
      hold_req = 1;
      random_phase(60);
      drain();
      write_threshold(32'h00FF_FFFF);
      random_phase(90);
      drain();
      write_threshold($urandom_range(1, 16777214));
      random_phase(90);
      drain();
      write_threshold(2000);
      quiet = 1;
      random_phase(90);
      req_valid <= 0;
      @(posedge clock);
      wait (pending == 0);
      repeat (100) @(posedge clock);

      $display("Covered %0d coefficient loads and %0d scored points, %0d results checked,",
               n_loads, n_points, n_results);
      $display("across five threshold settings with a long result-side hold.");
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
